FILE: rtl/bsa_pkg.sv
// ----------------------------------------------------------------------------
// bsa_pkg
// Shared widths, grid size and command codes of the binned sum accumulator.
// ----------------------------------------------------------------------------
package bsa_pkg;

  localparam int MaxBinsX = 64;
  localparam int MaxBinsY = 64;
  localparam int IdxXW    = $clog2(MaxBinsX);
  localparam int IdxYW    = $clog2(MaxBinsY);
  localparam int AddrW    = IdxXW + IdxYW;
  localparam int Depth    = MaxBinsX * MaxBinsY;

  localparam int CoordW   = 32;
  localparam int SumW     = 48;
  localparam int CntW     = 32;
  localparam int AvgW     = 32;
  localparam int BinsW    = 7;
  localparam int CmdW     = 3;
  localparam int CfgIdxW  = 3;

  typedef enum logic [CmdW-1:0] {
    CMD_ADD     = 3'd0,
    CMD_QIDX    = 3'd1,
    CMD_QCOORD  = 3'd2,
    CMD_SET_SUM = 3'd3,
    CMD_SET_CNT = 3'd4
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_X_LOWER = 3'd0,
    REG_X_UPPER = 3'd1,
    REG_Y_LOWER = 3'd2,
    REG_Y_UPPER = 3'd3,
    REG_BINS_X  = 3'd4,
    REG_BINS_Y  = 3'd5
  } reg_e;

endpackage

FILE: rtl/bsa_ram.sv
// ----------------------------------------------------------------------------
// bsa_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module bsa_ram #(
  parameter int Width = 32,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/bsa_avg_div.sv
// ----------------------------------------------------------------------------
// bsa_avg_div
// Bit-serial signed sum / unsigned count divider, truncating toward zero,
// result clamped to the signed average range.
// ----------------------------------------------------------------------------
module bsa_avg_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic signed [bsa_pkg::SumW-1:0] sum_i,
  input  logic [bsa_pkg::CntW-1:0]     cnt_i,
  output logic                         done_o,
  output logic [bsa_pkg::AvgW-1:0]     avg_o
);
  import bsa_pkg::*;

  localparam int StepW = $clog2(SumW);

  logic              busy_q, done_q, neg_q;
  logic [StepW-1:0]  step_q;
  logic [SumW-1:0]   a_q, quo_q;
  logic [CntW-1:0]   div_q;
  logic [CntW:0]     rem_q, rem_sh;
  logic              qbit;

  assign rem_sh = {rem_q[CntW-1:0], a_q[SumW-1]};
  assign qbit   = rem_sh >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= !start_i && busy_q && (step_q == StepW'(SumW - 1));
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        if (step_q == StepW'(SumW - 1)) begin
          busy_q <= 1'b0;
        end
        step_q <= step_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= sum_i[SumW-1];
      a_q   <= sum_i[SumW-1] ? SumW'(-sum_i) : SumW'(sum_i);
      div_q <= cnt_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= qbit ? rem_sh - {1'b0, div_q} : rem_sh;
      a_q   <= {a_q[SumW-2:0], 1'b0};
      quo_q <= {quo_q[SumW-2:0], qbit};
    end
  end

  // clamp the magnitude, then restore the sign
  always_comb begin
    if (!neg_q) begin
      if (quo_q[SumW-1:AvgW-1] != '0) avg_o = {1'b0, {(AvgW-1){1'b1}}};
      else                            avg_o = quo_q[AvgW-1:0];
    end else begin
      if (quo_q[SumW-1:AvgW] != '0 || (quo_q[AvgW-1] && quo_q[AvgW-2:0] != '0))
        avg_o = {1'b1, {(AvgW-1){1'b0}}};
      else
        avg_o = AvgW'(-quo_q[AvgW-1:0]);
    end
  end

  assign done_o = done_q;

endmodule

FILE: rtl/binned_2d_sum_average_accumulator.sv
// ----------------------------------------------------------------------------
// binned_2d_sum_average_accumulator
// Two-dimensional histogram of per-bin Q32.16 sums and sample counts.
// ----------------------------------------------------------------------------
// After reset the block clears all 4096 entries of both bin memories, one
// entry per cycle; in_ready_o stays low during that pass while configuration
// writes are taken. One word is processed at a time. An add or a query at a
// coordinate runs a 6-step bit-serial bin index division per axis. A query
// of a non-empty bin also runs the bit-serial sum / count divider. A result
// sits in an output register, so the next word can be accepted while it
// waits. Sums and counts live in two synchronous RAMs addressed by
// {bin_x, bin_y}; each add reads, modifies and writes back before the next
// word is accepted.
// ----------------------------------------------------------------------------
module binned_2d_sum_average_accumulator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bsa_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [31:0]                     cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [bsa_pkg::CmdW-1:0]        cmd_i,
  input  logic signed [31:0]              coord_x_i,
  input  logic signed [31:0]              coord_y_i,
  input  logic signed [31:0]              sample_value_i,
  input  logic [bsa_pkg::IdxXW-1:0]       index_x_i,
  input  logic [bsa_pkg::IdxYW-1:0]       index_y_i,
  input  logic signed [bsa_pkg::SumW-1:0] new_sum_i,
  input  logic [bsa_pkg::CntW-1:0]        new_count_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            status_o,
  output logic signed [bsa_pkg::SumW-1:0] bin_sum_o,
  output logic signed [bsa_pkg::AvgW-1:0] bin_average_o,
  output logic [bsa_pkg::CntW-1:0]        bin_count_o
);
  import bsa_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_PREP, S_MUL, S_BIN, S_READ, S_DATA, S_AVG, S_OUT
  } state_e;

  localparam int NumW = CoordW + 1;        // coordinate minus edge
  localparam int ProdW = CoordW + BinsW;   // offset times bin count
  localparam int BinStepW = $clog2(IdxXW > IdxYW ? IdxXW : IdxYW);
  localparam logic [SumW-1:0] NegOneSum = SumW'(-65536);
  localparam logic [AvgW-1:0] NegOneAvg = AvgW'(-65536);

  state_e state_q;

  // configuration
  logic signed [CoordW-1:0] x_lo_q, x_hi_q, y_lo_q, y_hi_q;
  logic [BinsW-1:0]         bins_x_q, bins_y_q, nbx, nby;

  // latched word
  cmd_e                     cmd_q;
  logic signed [CoordW-1:0] cx_q, cy_q, val_q;
  logic [IdxXW-1:0]         ix_q;
  logic [IdxYW-1:0]         iy_q;
  logic signed [SumW-1:0]   nsum_q;
  logic [CntW-1:0]          ncnt_q;

  // bin index datapath
  logic signed [NumW-1:0]   num_x_q, num_y_q, d_x_q, d_y_q;
  logic                     ok_x_q, ok_y_q;
  logic [ProdW-1:0]         p_x_q, p_y_q;
  logic [ProdW-1:0]         dsh_x_q, dsh_y_q;
  logic [IdxXW-1:0]         qx_q;
  logic [IdxYW-1:0]         qy_q;
  logic [BinStepW-1:0]      bstep_q;
  logic                     ge_x, ge_y;
  logic signed [NumW-1:0]   num_x, num_y, d_x, d_y;

  logic [AddrW-1:0]         addr_q, clr_q;
  logic                     idx_ok;

  // result staging and output register
  logic                     res_status_q, out_status_q, out_valid_q;
  logic [SumW-1:0]          res_sum_q, out_sum_q;
  logic [AvgW-1:0]          res_avg_q, out_avg_q;
  logic [CntW-1:0]          res_cnt_q, out_cnt_q;

  // memory ports
  logic                     sum_we, cnt_we;
  logic [AddrW-1:0]         waddr;
  logic [SumW-1:0]          sum_wdata, sum_rdata;
  logic [CntW-1:0]          cnt_wdata, cnt_rdata;
  logic signed [SumW:0]     sum_add;
  logic [SumW-1:0]          sum_sat;

  logic                     div_start, div_done;
  logic [AvgW-1:0]          div_avg;

  assign nbx = (bins_x_q > BinsW'(MaxBinsX)) ? BinsW'(MaxBinsX) : bins_x_q;
  assign nby = (bins_y_q > BinsW'(MaxBinsY)) ? BinsW'(MaxBinsY) : bins_y_q;
  assign idx_ok = ({1'b0, ix_q} < nbx) && ({1'b0, iy_q} < nby);

  assign num_x = NumW'(cx_q) - NumW'(x_lo_q);
  assign num_y = NumW'(cy_q) - NumW'(y_lo_q);
  assign d_x   = NumW'(x_hi_q) - NumW'(x_lo_q);
  assign d_y   = NumW'(y_hi_q) - NumW'(y_lo_q);

  assign ge_x = p_x_q >= dsh_x_q;
  assign ge_y = p_y_q >= dsh_y_q;

  // saturating add of the sample to the stored sum
  assign sum_add = {sum_rdata[SumW-1], sum_rdata} + (SumW+1)'(val_q);
  always_comb begin
    if (sum_add[SumW] != sum_add[SumW-1])
      sum_sat = sum_add[SumW] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};
    else
      sum_sat = sum_add[SumW-1:0];
  end

  // memory write port: clear pass, direct sets, add write-back
  always_comb begin
    sum_we    = 1'b0;
    cnt_we    = 1'b0;
    waddr     = addr_q;
    sum_wdata = sum_sat;
    cnt_wdata = (cnt_rdata == '1) ? cnt_rdata : cnt_rdata + 1'b1;
    unique case (state_q)
      S_CLEAR: begin
        sum_we    = 1'b1;
        cnt_we    = 1'b1;
        waddr     = clr_q;
        sum_wdata = '0;
        cnt_wdata = '0;
      end
      S_DECODE: begin
        waddr     = {ix_q, iy_q};
        sum_wdata = nsum_q;
        cnt_wdata = ncnt_q;
        sum_we    = idx_ok && (cmd_q == CMD_SET_SUM);
        cnt_we    = idx_ok && (cmd_q == CMD_SET_CNT);
      end
      S_DATA: begin
        sum_we = (cmd_q == CMD_ADD);
        cnt_we = (cmd_q == CMD_ADD);
      end
      default: ;
    endcase
  end

  assign div_start = (state_q == S_DATA) && (cmd_q != CMD_ADD) && (cnt_rdata != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      x_lo_q      <= '0;
      x_hi_q      <= 32'sd65536;
      y_lo_q      <= '0;
      y_hi_q      <= 32'sd65536;
      bins_x_q    <= 7'd64;
      bins_y_q    <= 7'd64;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_X_LOWER: x_lo_q   <= cfg_data_i;
          REG_X_UPPER: x_hi_q   <= cfg_data_i;
          REG_Y_LOWER: y_lo_q   <= cfg_data_i;
          REG_Y_UPPER: y_hi_q   <= cfg_data_i;
          REG_BINS_X:  bins_x_q <= cfg_data_i[BinsW-1:0];
          REG_BINS_Y:  bins_y_q <= cfg_data_i[BinsW-1:0];
          default: ;
        endcase
      end

      // drop the taken word unless a new one is loaded this cycle
      if (out_valid_q && out_ready_i && state_q != S_OUT) out_valid_q <= 1'b0;

      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == '1) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid_i) begin
            cmd_q   <= cmd_e'(cmd_i);
            cx_q    <= coord_x_i;
            cy_q    <= coord_y_i;
            val_q   <= sample_value_i;
            ix_q    <= index_x_i;
            iy_q    <= index_y_i;
            nsum_q  <= new_sum_i;
            ncnt_q  <= new_count_i;
            state_q <= S_DECODE;
          end
        end
        S_DECODE: begin
          res_cnt_q <= '0;
          case (cmd_q)
            CMD_ADD, CMD_QCOORD: begin
              res_status_q <= 1'b0;
              res_sum_q    <= '0;
              res_avg_q    <= '0;
              state_q      <= S_PREP;
            end
            CMD_QIDX: begin
              addr_q       <= {ix_q, iy_q};
              res_status_q <= !idx_ok;
              res_sum_q    <= idx_ok ? '0 : NegOneSum;
              res_avg_q    <= idx_ok ? '0 : NegOneAvg;
              state_q      <= idx_ok ? S_READ : S_OUT;
            end
            CMD_SET_SUM, CMD_SET_CNT: begin
              res_status_q <= !idx_ok;
              res_sum_q    <= '0;
              res_avg_q    <= '0;
              state_q      <= S_OUT;
            end
            default: begin
              res_status_q <= 1'b0;
              res_sum_q    <= '0;
              res_avg_q    <= '0;
              state_q      <= S_OUT;
            end
          endcase
        end
        S_PREP: begin
          // in range exactly when bins are nonzero and 0 <= offset < span; then index < bins
          num_x_q <= num_x;
          num_y_q <= num_y;
          d_x_q   <= d_x;
          d_y_q   <= d_y;
          ok_x_q  <= (nbx != '0) && !num_x[NumW-1] && (num_x < d_x);
          ok_y_q  <= (nby != '0) && !num_y[NumW-1] && (num_y < d_y);
          state_q <= S_MUL;
        end
        S_MUL: begin
          p_x_q   <= ProdW'(num_x_q[CoordW-1:0]) * ProdW'(nbx);
          p_y_q   <= ProdW'(num_y_q[CoordW-1:0]) * ProdW'(nby);
          dsh_x_q <= ProdW'(d_x_q[CoordW-1:0]) << (IdxXW - 1);
          dsh_y_q <= ProdW'(d_y_q[CoordW-1:0]) << (IdxYW - 1);
          qx_q    <= '0;
          qy_q    <= '0;
          bstep_q <= '0;
          state_q <= S_BIN;
        end
        S_BIN: begin
          // one quotient bit per cycle on each axis
          if (bstep_q < BinStepW'(IdxXW)) begin
            if (ge_x) p_x_q <= p_x_q - dsh_x_q;
            qx_q    <= {qx_q[IdxXW-2:0], ge_x};
            dsh_x_q <= dsh_x_q >> 1;
          end
          if (bstep_q < BinStepW'(IdxYW)) begin
            if (ge_y) p_y_q <= p_y_q - dsh_y_q;
            qy_q    <= {qy_q[IdxYW-2:0], ge_y};
            dsh_y_q <= dsh_y_q >> 1;
          end
          bstep_q <= bstep_q + 1'b1;
          if (bstep_q == BinStepW'((IdxXW > IdxYW ? IdxXW : IdxYW) - 1)) begin
            if (ok_x_q && ok_y_q) begin
              state_q <= S_READ;
            end else begin
              res_status_q <= 1'b1;
              if (cmd_q == CMD_QCOORD) begin
                res_sum_q <= NegOneSum;
                res_avg_q <= NegOneAvg;
              end
              state_q <= S_OUT;
            end
          end
        end
        S_READ: begin
          // hold the address while the registered RAM read completes
          if (cmd_q == CMD_QIDX) begin
            state_q <= S_DATA;
          end else begin
            addr_q <= {qx_q, qy_q};
            if (addr_q == {qx_q, qy_q}) state_q <= S_DATA;
          end
        end
        S_DATA: begin
          if (cmd_q != CMD_ADD) begin
            res_sum_q <= sum_rdata;
            res_cnt_q <= cnt_rdata;
            res_avg_q <= '0;
          end
          state_q <= div_start ? S_AVG : S_OUT;
        end
        S_AVG: begin
          if (div_done) begin
            res_avg_q <= div_avg;
            state_q   <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q  <= 1'b1;
            out_status_q <= res_status_q;
            out_sum_q    <= res_sum_q;
            out_avg_q    <= res_avg_q;
            out_cnt_q    <= res_cnt_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  bsa_ram #(.Width(SumW), .Depth(Depth)) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (sum_we),
    .waddr_i (waddr),
    .wdata_i (sum_wdata),
    .raddr_i (addr_q),
    .rdata_o (sum_rdata)
  );

  bsa_ram #(.Width(CntW), .Depth(Depth)) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (waddr),
    .wdata_i (cnt_wdata),
    .raddr_i (addr_q),
    .rdata_o (cnt_rdata)
  );

  bsa_avg_div u_avg_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .sum_i   (sum_rdata),
    .cnt_i   (cnt_rdata),
    .done_o  (div_done),
    .avg_o   (div_avg)
  );

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign bin_sum_o     = out_sum_q;
  assign bin_average_o = out_avg_q;
  assign bin_count_o   = out_cnt_q;

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the binned 2D sum and average accumulator. Directed
// and random words drive all five commands and unused codes through a
// valid/ready input. A local grid model predicts every result, and the results
// are checked field by field as they leave the block under random output
// stalls. The range and bin registers are swept between phases, extremes
// included.
// ----------------------------------------------------------------------------
module testbench;
  import bsa_pkg::*;

  localparam int  ClkHalf       = 4;
  localparam int  CycleLimit    = 1000000;
  localparam int  SettleCycles  = 80;     // longest word: coord query plus divider
  localparam logic [CmdW-1:0] CmdUnusedFirst = 3'd5;
  localparam logic [CmdW-1:0] CmdUnusedLast  = 3'd7;
  localparam longint SumMax = 64'sd140737488355327;
  localparam longint SumMin = -64'sd140737488355328;
  localparam longint NegOne = -64'sd65536;

  typedef struct {
    logic [CmdW-1:0]     cmd;
    logic signed [31:0]  cx;
    logic signed [31:0]  cy;
    logic signed [31:0]  val;
    logic [IdxXW-1:0]    ix;
    logic [IdxYW-1:0]    iy;
    logic signed [SumW-1:0] nsum;
    logic [CntW-1:0]     ncnt;
  } word_t;

  typedef struct {
    logic                   status;
    logic signed [SumW-1:0] sum;
    logic signed [AvgW-1:0] avg;
    logic [CntW-1:0]        cnt;
  } bin_result_t;

  // DUT signals; the inputs are known from time zero
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [CmdW-1:0] cmd_i = '0;
  logic signed [31:0] coord_x_i = '0, coord_y_i = '0, sample_value_i = '0;
  logic [IdxXW-1:0] index_x_i = '0;
  logic [IdxYW-1:0] index_y_i = '0;
  logic signed [SumW-1:0] new_sum_i = '0;
  logic [CntW-1:0] new_count_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic status_o;
  logic signed [SumW-1:0] bin_sum_o;
  logic signed [AvgW-1:0] bin_average_o;
  logic [CntW-1:0] bin_count_o;

  binned_2d_sum_average_accumulator u_top (.*);

  // Grid model state and register copies
  longint      grid_sum [Depth];
  logic [31:0] grid_cnt [Depth];
  longint      x_lo, x_hi, y_lo, y_hi;
  int          bins_x_reg, bins_y_reg;

  bin_result_t pending_results[$];
  int          mismatches = 0;
  int          words_sent = 0;
  int          results_seen = 0;
  int          out_of_range_seen = 0;
  int          cycle_count = 0;
  int          hold_off = 0;
  int          burst_left = 0;

  initial begin
    forever #(ClkHalf) clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- model
  function automatic int used_bins(int reg_val, int max_bins);
    return (reg_val > max_bins) ? max_bins : reg_val;
  endfunction

  // Exact floor bin index; zero for an empty range or outside [0, n)
  function automatic bit locate_bin(longint c, longint lo, longint hi, int n,
                                    output int idx);
    longint q;
    idx = 0;
    if (n == 0 || hi <= lo || c < lo) return 1'b0;
    q = ((c - lo) * longint'(n)) / (hi - lo);
    if (q >= n) return 1'b0;
    idx = int'(q);
    return 1'b1;
  endfunction

  function automatic bin_result_t predict_bin_result(word_t w);
    bin_result_t r;
    int nbx, nby, bx, by, k;
    bit ok;
    longint s, avg;
    nbx = used_bins(bins_x_reg, MaxBinsX);
    nby = used_bins(bins_y_reg, MaxBinsY);
    r = '{1'b0, '0, '0, '0};
    case (w.cmd)
      CMD_ADD: begin
        ok = w.cx >= x_lo && w.cx <= x_hi && w.cy >= y_lo && w.cy <= y_hi &&
             locate_bin(w.cx, x_lo, x_hi, nbx, bx) &&
             locate_bin(w.cy, y_lo, y_hi, nby, by);
        if (!ok) begin
          r.status = 1'b1;
        end else begin
          k = bx * MaxBinsY + by;
          s = grid_sum[k] + longint'(w.val);
          if (s > SumMax) s = SumMax;
          if (s < SumMin) s = SumMin;
          grid_sum[k] = s;
          if (grid_cnt[k] != 32'hFFFF_FFFF) grid_cnt[k] = grid_cnt[k] + 1;
        end
      end
      CMD_QIDX, CMD_QCOORD: begin
        if (w.cmd == CMD_QIDX) begin
          bx = w.ix; by = w.iy;
          ok = bx < nbx && by < nby;
        end else begin
          ok = locate_bin(w.cx, x_lo, x_hi, nbx, bx) &&
               locate_bin(w.cy, y_lo, y_hi, nby, by);
        end
        if (ok) begin
          k = bx * MaxBinsY + by;
          avg = 0;
          if (grid_cnt[k] != 0) begin
            avg = grid_sum[k] / longint'({32'd0, grid_cnt[k]});
            if (avg > 64'sd2147483647) avg = 64'sd2147483647;
            if (avg < -64'sd2147483648) avg = -64'sd2147483648;
          end
          r.sum = grid_sum[k][SumW-1:0];
          r.avg = avg[AvgW-1:0];
          r.cnt = grid_cnt[k];
        end else begin
          r.status = 1'b1;
          r.sum = NegOne[SumW-1:0];
          r.avg = NegOne[AvgW-1:0];
        end
      end
      CMD_SET_SUM, CMD_SET_CNT: begin
        if (!(w.ix < nbx && w.iy < nby)) begin
          r.status = 1'b1;
        end else if (w.cmd == CMD_SET_SUM) begin
          grid_sum[w.ix * MaxBinsY + w.iy] = longint'(w.nsum);
        end else begin
          grid_cnt[w.ix * MaxBinsY + w.iy] = w.ncnt;
        end
      end
      default: ;  // unused codes change nothing
    endcase
    return r;
  endfunction

  // ----------------------------------------------------------- reporting
  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d",
             cycle_count, what, got, want);
    mismatches++;
  endtask

  // Check every word leaving the block against the oldest prediction
  always @(posedge clk_i) begin
    bin_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result word, count", results_seen, 0);
      end else begin
        want = pending_results.pop_front();
        if (want.status) out_of_range_seen++;
        if (status_o !== want.status) report_mismatch("status", status_o, want.status);
        if (bin_sum_o !== want.sum) report_mismatch("bin_sum", bin_sum_o, want.sum);
        if (bin_average_o !== want.avg)
          report_mismatch("bin_average", bin_average_o, want.avg);
        if (bin_count_o !== want.cnt) report_mismatch("bin_count", bin_count_o, want.cnt);
      end
    end
  end

  // Receiver: rotate between free flow, light and heavy stalls; honor hold-off
  always @(posedge clk_i) begin
    cycle_count++;
    if (hold_off > 0) begin
      hold_off--;
      out_ready_i <= 1'b0;
    end else begin
      case ((cycle_count / 300) % 3)
        0:       out_ready_i <= 1'b1;
        1:       out_ready_i <= ($urandom_range(0, 3) != 0);
        default: out_ready_i <= ($urandom_range(0, 2) == 0);
      endcase
    end
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  // ------------------------------------------------------------- drivers
  task automatic write_reg(reg_e idx, logic [31:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      REG_X_LOWER: x_lo = longint'(signed'(data));
      REG_X_UPPER: x_hi = longint'(signed'(data));
      REG_Y_LOWER: y_lo = longint'(signed'(data));
      REG_Y_UPPER: y_hi = longint'(signed'(data));
      REG_BINS_X:  bins_x_reg = data[BinsW-1:0];
      REG_BINS_Y:  bins_y_reg = data[BinsW-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_grid(logic [31:0] xl, logic [31:0] xh, logic [31:0] yl,
                          logic [31:0] yh, logic [31:0] bx, logic [31:0] by);
    write_reg(REG_X_LOWER, xl);
    write_reg(REG_X_UPPER, xh);
    write_reg(REG_Y_LOWER, yl);
    write_reg(REG_Y_UPPER, yh);
    write_reg(REG_BINS_X, bx);
    write_reg(REG_BINS_Y, by);
  endtask

  // Offer one word, hold it until taken, then predict its result
  task automatic send_word(word_t w);
    in_valid_i     <= 1'b1;
    cmd_i          <= w.cmd;
    coord_x_i      <= w.cx;
    coord_y_i      <= w.cy;
    sample_value_i <= w.val;
    index_x_i      <= w.ix;
    index_y_i      <= w.iy;
    new_sum_i      <= w.nsum;
    new_count_i    <= w.ncnt;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(predict_bin_result(w));
    words_sent++;
  endtask

  // Send in bursts with random gaps between them
  task automatic send_paced(word_t w);
    send_word(w);
    if (--burst_left <= 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic word_t make_word(logic [CmdW-1:0] cmd, longint cx, longint cy,
                                      longint val, int ix, int iy,
                                      longint nsum, longint ncnt);
    word_t w;
    w.cmd = cmd; w.cx = cx[31:0]; w.cy = cy[31:0]; w.val = val[31:0];
    w.ix = ix[IdxXW-1:0]; w.iy = iy[IdxYW-1:0];
    w.nsum = nsum[SumW-1:0]; w.ncnt = ncnt[CntW-1:0];
    return w;
  endfunction

  function automatic longint pick_in(longint lo, longint hi);
    longint span;
    if (hi < lo) return lo;
    span = hi - lo + 1;
    return lo + longint'({$urandom, $urandom} % unsigned'(span));
  endfunction

  // Mostly well-formed words aimed inside the grid; the rest is full-range noise
  function automatic word_t rand_word();
    word_t w;
    int nbx, nby, pick;
    nbx = used_bins(bins_x_reg, MaxBinsX);
    nby = used_bins(bins_y_reg, MaxBinsY);
    w.cmd  = $urandom_range(0, 100) < 45 ? CMD_ADD : $urandom_range(CMD_QIDX, CMD_SET_CNT);
    w.cx   = (x_hi >= x_lo && $urandom_range(0, 9) != 0) ? pick_in(x_lo, x_hi) : $urandom;
    w.cy   = (y_hi >= y_lo && $urandom_range(0, 9) != 0) ? pick_in(y_lo, y_hi) : $urandom;
    w.val  = $urandom_range(0, 3) == 0 ? $urandom : $signed($urandom_range(0, 1 << 20))
             - 32'sd524288;
    pick   = $urandom_range(0, 9);
    w.ix   = (pick < 8 && nbx > 0) ? $urandom_range(0, nbx - 1) : $urandom;
    w.iy   = (pick < 8 && nby > 0) ? $urandom_range(0, nby - 1) : $urandom;
    w.nsum = {$urandom, $urandom};
    w.ncnt = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 20);
    if ($urandom_range(0, 60) == 0) w.cmd = $urandom_range(CmdUnusedFirst, CmdUnusedLast);
    return w;
  endfunction

  // ---------------------------------------------------------------- tests
  task automatic test_directed();
    send_word(make_word(CMD_QIDX, 0, 0, 0, 0, 0, 0, 0));          // empty bin, zero average
    send_word(make_word(CMD_ADD, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, 0));
    send_word(make_word(CMD_ADD, 0, 0, -64'sd2147483648, 0, 0, 0, 0));
    send_word(make_word(CMD_ADD, 65535, 65535, 196608, 0, 0, 0, 0));
    send_word(make_word(CMD_ADD, 65536, 100, 5, 0, 0, 0, 0));      // upper edge: dropped
    send_word(make_word(CMD_ADD, -1, 100, 5, 0, 0, 0, 0));         // below range
    send_word(make_word(CMD_QCOORD, 65536, 0, 0, 0, 0, 0, 0));     // upper edge query
    send_word(make_word(CMD_QCOORD, 65535, 65535, 0, 0, 0, 0, 0));
    send_word(make_word(CMD_QIDX, 0, 0, 0, 0, 0, 0, 0));
    send_word(make_word(CMD_SET_SUM, 0, 0, 0, 5, 6, SumMax, 0));   // saturate sum up
    send_word(make_word(CMD_ADD, 5 * 1024, 6 * 1024, 32'h7FFF_FFFF, 0, 0, 0, 0));
    send_word(make_word(CMD_SET_CNT, 0, 0, 0, 5, 6, 0, 32'hFFFF_FFFF));
    send_word(make_word(CMD_ADD, 5 * 1024, 6 * 1024, 7, 0, 0, 0, 0)); // count stops
    send_word(make_word(CMD_QIDX, 0, 0, 0, 5, 6, 0, 0));
    send_word(make_word(CMD_SET_SUM, 0, 0, 0, 63, 63, SumMin, 0));
    send_word(make_word(CMD_SET_CNT, 0, 0, 0, 63, 63, 0, 1));      // average clamps low
    send_word(make_word(CMD_ADD, 65535, 65535, -64'sd2147483648, 0, 0, 0, 0));
    send_word(make_word(CMD_QIDX, 0, 0, 0, 63, 63, 0, 0));
    send_word(make_word(CMD_SET_CNT, 0, 0, 0, 63, 63, 0, 0));      // count zero, sum not
    send_word(make_word(CMD_QIDX, 0, 0, 0, 63, 63, 0, 0));
    send_word(make_word(CmdUnusedFirst, 1, 1, 1, 1, 1, 1, 1));
    send_word(make_word(CmdUnusedLast, -1, -1, -1, 63, 63, -1, 32'hFFFF_FFFF));
    wait_drained();
  endtask

  task automatic random_phase(int n_words);
    repeat (n_words) send_paced(rand_word());
    wait_drained();
  endtask

  task automatic test_config_sweep();
    // Widest range, one bin each way
    set_grid(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1, 1);
    send_word(make_word(CMD_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 9, 0, 0, 0, 0));
    send_word(make_word(CMD_ADD, 32'h7FFF_FFFE, 32'h8000_0000, 9, 0, 0, 0, 0));
    send_word(make_word(CMD_QIDX, 0, 0, 0, 1, 0, 0, 0));
    random_phase(120);
    // Bins above maximum saturate, skewed narrow range
    set_grid(32'hFFFF_0000, 32'h0000_0003, 32'h7FFF_FF00, 32'h7FFF_FFFF, 127, 100);
    random_phase(150);
    // Zero bins: nothing is in range
    set_grid(0, 65536, 0, 65536, 0, 13);
    random_phase(60);
    // Empty and inverted ranges
    set_grid(1000, 1000, 5000, -5000, 17, 9);
    random_phase(60);
    // Odd bin counts over a wide signed span
    set_grid(32'hC000_0000, 32'h3FFF_FFFF, 32'hF000_0000, 32'h1234_5678, 7, 63);
    random_phase(200);
  endtask

  task automatic test_random();
    set_grid(-64'sd655360, 64'sd655360, 0, 64'sd327680, 64, 33);
    random_phase(1000);
  endtask

  task automatic test_backpressure();
    set_grid(0, 65536, 0, 65536, 4, 4);
    // Long receiver hold-off while the sender keeps offering
    hold_off = 600;
    repeat (40) send_word(rand_word());
    // Pause until the block has caught up, then resume
    wait_drained();
    random_phase(150);
  endtask

  initial begin
    x_lo = 0; x_hi = 65536; y_lo = 0; y_hi = 65536;
    bins_x_reg = 64; bins_y_reg = 64;
    foreach (grid_sum[k]) begin
      grid_sum[k] = 0;
      grid_cnt[k] = '0;
    end
    burst_left = $urandom_range(1, 24);
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_config_sweep();
    test_random();
    test_backpressure();
    wait_drained();
    $display("covered %0d words and %0d results, %0d of them out of range,",
             words_sent, results_seen, out_of_range_seen);
    $display("across range, bin count and stall sweeps; %0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
